// ===== rtl/core/rdl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdl_pkg
// Shared widths, register indexes and divider handshake types for the
// ramped delay line.
// ----------------------------------------------------------------------------
package rdl_pkg;

    // Width of delays, lengths and block sizes as seen on the register port
    localparam int DLY_W      = 13;
    localparam int POS_W      = 12;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 13;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BUFFER_LENGTH = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_DELAY  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_ENABLE   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH  = 8'd3;

    // Divider request and response
    typedef struct packed {
        logic                   start;
        logic [2*DLY_W-1:0]     numer;
        logic [DLY_W-1:0]       denom;
    } rdl_div_req_t;

    typedef struct packed {
        logic                   done;
        logic [DLY_W-1:0]       quot;
    } rdl_div_rsp_t;

endpackage

// ===== rtl/core/ramped_delay_line.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ramped_delay_line
// Circular-buffer audio delay line with an optional linear delay ramp.
// ----------------------------------------------------------------------------
// After reset the block first sweeps the sample memory to zero, one entry a
// cycle, so it takes no input item until the sweep ends (configuration
// writes are taken throughout). One item is processed at a time: it passes
// ST_ADDR, ST_READ and ST_OUT in direct mode, and ST_MUL and ST_DIV first in
// ramp mode, where the ramp delay start + (target-start)*pos/block_length is
// found by a 13-step bit-serial divider. A new item is taken only once the
// previous result has gone to the output register; the next item may be
// accepted while that result still waits on the output register.
// Configuration is to be written only while idle.
module ramped_delay_line #(
    parameter int DEPTH       = 4096,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rdl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rdl_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input items
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [SAMPLE_BITS-1:0]     sample_in,
    input  logic [rdl_pkg::POS_W-1:0]         position_in_block,
    input  logic                              commit_delay,
    // result items
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [SAMPLE_BITS-1:0]     sample_out
);
    import rdl_pkg::*;

    // Address width, length width (holds DEPTH and any 13-bit register value),
    // and one extra bit for the wrap sum in the read address calculation.
    localparam int AW  = $clog2(DEPTH);
    localparam int LW0 = $clog2(DEPTH + 1);
    localparam int LW  = (LW0 > DLY_W) ? LW0 : DLY_W;
    localparam int CW  = LW + 1;

    localparam logic [LW-1:0] DEPTH_L = LW'(DEPTH);

    // Sequencer: clear sweep, idle, ramp multiply, divide, read address,
    // read/write-back, hand over to the output register.
    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_MUL   = 7'b0000100,
        ST_DIV   = 7'b0001000,
        ST_ADDR  = 7'b0010000,
        ST_READ  = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t                 state_reg, state_next;

    // Configuration registers
    logic [DLY_W-1:0]       buf_len_reg, buf_len_next;
    logic [DLY_W-1:0]       tgt_cfg_reg, tgt_cfg_next;
    logic                   ramp_en_reg, ramp_en_next;
    logic [DLY_W-1:0]       blk_len_reg, blk_len_next;

    // Persistent state
    logic [AW-1:0]          wpos_reg,      wpos_next;
    logic [DLY_W-1:0]       start_dly_reg, start_dly_next;
    logic [AW-1:0]          clr_reg,       clr_next;
    logic                   out_valid_reg, out_valid_next;

    // Per-item working registers (no reset needed)
    logic [SAMPLE_BITS-1:0] smp_reg,    smp_next;
    logic [POS_W-1:0]       pos_reg,    pos_next;
    logic                   commit_reg, commit_next;
    logic [LW-1:0]          len_reg,    len_next;
    logic [DLY_W-1:0]       tgt_reg,    tgt_next;
    logic [DLY_W-1:0]       strt_reg,   strt_next;
    logic [AW-1:0]          wp_reg,     wp_next;
    logic [DLY_W-1:0]       dly_reg,    dly_next;
    logic [SAMPLE_BITS-1:0] res_reg,    res_next;
    logic [SAMPLE_BITS-1:0] sout_reg,   sout_next;

    // Clamps applied when an item is taken
    logic [LW-1:0]          len_c;
    logic [DLY_W-1:0]       tgt_c;
    logic [DLY_W-1:0]       strt_c;
    logic [AW-1:0]          wp_c;
    logic                   in_acc;

    // Ramp datapath
    logic [DLY_W-1:0]       blk_eff;
    logic [DLY_W-1:0]       pos_ext;
    logic [DLY_W-1:0]       pos_sat;
    logic                   ramp_down;
    logic [DLY_W-1:0]       diff;
    rdl_div_req_t           div_req;
    rdl_div_rsp_t           div_rsp;

    // Read address and write-back
    logic [CW-1:0]          wp_w, d_w, len_w, rd_w;
    logic [AW-1:0]          rd_addr;
    logic [LW-1:0]          wp_inc;

    // Memory port
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [SAMPLE_BITS-1:0] mem_wdata;
    logic                   mem_re;
    logic [SAMPLE_BITS-1:0] mem_rdata;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign sample_out = sout_reg;

    // Length in use: register clamped to 1..DEPTH; target and start clamped
    // to that length; a stale write position past the end restarts at 0.
    always_comb
    begin
        if (buf_len_reg == '0)
        begin
            len_c = LW'(1);
        end
        else if (LW'(buf_len_reg) > DEPTH_L)
        begin
            len_c = DEPTH_L;
        end
        else
        begin
            len_c = LW'(buf_len_reg);
        end
        tgt_c  = (LW'(tgt_cfg_reg) > len_c)   ? DLY_W'(len_c) : tgt_cfg_reg;
        strt_c = (LW'(start_dly_reg) > len_c) ? DLY_W'(len_c) : start_dly_reg;
        wp_c   = (LW'(wpos_reg) >= len_c)     ? '0 : wpos_reg;
    end

    // Ramp: |target - start| * saturated position, divided by block length
    // (zero length treated as one). Quotient never exceeds |target - start|.
    assign blk_eff   = (blk_len_reg == '0) ? DLY_W'(1) : blk_len_reg;
    assign pos_ext   = DLY_W'(pos_reg);
    assign pos_sat   = (pos_ext > blk_eff) ? blk_eff : pos_ext;
    assign ramp_down = (tgt_reg < strt_reg);
    assign diff      = ramp_down ? (strt_reg - tgt_reg) : (tgt_reg - strt_reg);

    assign div_req.start = (state_reg == ST_MUL);
    assign div_req.numer = (2*DLY_W)'(diff) * (2*DLY_W)'(pos_sat);
    assign div_req.denom = blk_eff;

    rdl_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Read address: write position minus delay, modulo the length in use.
    // A delay equal to the length lands on the entry about to be overwritten;
    // it is read in ST_ADDR, before ST_READ writes it: the old sample returns.
    always_comb
    begin
        wp_w  = CW'(wp_reg);
        d_w   = CW'(dly_reg);
        len_w = CW'(len_reg);
        if (wp_w >= d_w)
        begin
            rd_w = wp_w - d_w;
        end
        else
        begin
            rd_w = wp_w + len_w - d_w;
        end
        rd_addr = (rd_w >= len_w) ? '0 : rd_w[AW-1:0];
    end

    assign wp_inc = LW'(wp_reg) + LW'(1);

    // Memory port: the clear sweep and the item write-back share the write port
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = wp_reg;
        mem_wdata = smp_reg;
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
            mem_wdata = '0;
        end
        else if (state_reg == ST_READ)
        begin
            mem_we = 1'b1;
        end
    end

    assign mem_re = (state_reg == ST_ADDR);

    rdl_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (rd_addr),
        .rdata (mem_rdata)
    );

    // Configuration decode
    always_comb
    begin
        buf_len_next = buf_len_reg;
        tgt_cfg_next = tgt_cfg_reg;
        ramp_en_next = ramp_en_reg;
        blk_len_next = blk_len_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_BUFFER_LENGTH: buf_len_next = cfg_data;
                REG_TARGET_DELAY:  tgt_cfg_next = cfg_data;
                REG_RAMP_ENABLE:   ramp_en_next = cfg_data[0];
                REG_BLOCK_LENGTH:  blk_len_next = cfg_data;
                default:           ;
            endcase
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        wpos_next      = wpos_reg;
        start_dly_next = start_dly_reg;
        out_valid_next = out_valid_reg;
        smp_next       = smp_reg;
        pos_next       = pos_reg;
        commit_next    = commit_reg;
        len_next       = len_reg;
        tgt_next       = tgt_reg;
        strt_next      = strt_reg;
        wp_next        = wp_reg;
        dly_next       = dly_reg;
        res_next       = res_reg;
        sout_next      = sout_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    smp_next    = sample_in;
                    pos_next    = position_in_block;
                    commit_next = commit_delay;
                    len_next    = len_c;
                    tgt_next    = tgt_c;
                    strt_next   = strt_c;
                    wp_next     = wp_c;
                    dly_next    = tgt_c;
                    state_next  = ramp_en_reg ? ST_MUL : ST_ADDR;
                end
            end
            ST_MUL:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    dly_next   = ramp_down ? (strt_reg - div_rsp.quot)
                                           : (strt_reg + div_rsp.quot);
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                state_next = ST_READ;
            end
            ST_READ:
            begin
                // zero delay bypasses the memory
                res_next  = (dly_reg == '0) ? smp_reg : mem_rdata;
                wpos_next = (wp_inc >= len_reg) ? '0 : wp_inc[AW-1:0];
                if (commit_reg)
                begin
                    start_dly_next = tgt_reg;
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    sout_next      = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            wpos_reg      <= '0;
            start_dly_reg <= '0;
            out_valid_reg <= 1'b0;
            buf_len_reg   <= DLY_W'(4096);
            tgt_cfg_reg   <= '0;
            ramp_en_reg   <= 1'b0;
            blk_len_reg   <= DLY_W'(256);
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            wpos_reg      <= wpos_next;
            start_dly_reg <= start_dly_next;
            out_valid_reg <= out_valid_next;
            buf_len_reg   <= buf_len_next;
            tgt_cfg_reg   <= tgt_cfg_next;
            ramp_en_reg   <= ramp_en_next;
            blk_len_reg   <= blk_len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg    <= smp_next;
        pos_reg    <= pos_next;
        commit_reg <= commit_next;
        len_reg    <= len_next;
        tgt_reg    <= tgt_next;
        strt_reg   <= strt_next;
        wp_reg     <= wp_next;
        dly_reg    <= dly_next;
        res_reg    <= res_next;
        sout_reg   <= sout_next;
    end

endmodule

// ===== rtl/core/rdl_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdl_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module rdl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/rdl_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdl_div
// Restoring divider, one quotient bit per cycle. The quotient must fit in
// DLY_W bits, i.e. the upper half of the numerator is below the divisor.
// ----------------------------------------------------------------------------
module rdl_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rdl_pkg::rdl_div_req_t req,
    output rdl_pkg::rdl_div_rsp_t rsp
);
    import rdl_pkg::*;

    localparam int CNT_W = $clog2(DLY_W + 1);

    logic               run_reg,  run_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg,  cnt_next;
    logic [DLY_W-1:0]   rem_reg,  rem_next;
    logic [DLY_W-1:0]   low_reg,  low_next;
    logic [DLY_W-1:0]   den_reg,  den_next;
    logic [DLY_W-1:0]   quot_reg, quot_next;
    logic [DLY_W:0]     trial;
    logic               fits;

    assign trial = {rem_reg, low_reg[DLY_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        if (req.start)
        begin
            run_next = 1'b1;
            cnt_next = CNT_W'(DLY_W);
            rem_next = req.numer[2*DLY_W-1:DLY_W];
            low_next = req.numer[DLY_W-1:0];
            den_next = req.denom;
        end
        else if (run_reg)
        begin
            rem_next  = fits ? DLY_W'(trial - {1'b0, den_reg}) : trial[DLY_W-1:0];
            quot_next = {quot_reg[DLY_W-2:0], fits};
            low_next  = {low_reg[DLY_W-2:0], 1'b0};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        low_reg  <= low_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for ramped_delay_line. A queue of pending items,
// register writes and drain marks feeds a clocked driver; a clocked monitor
// takes the delayed samples under random back-pressure and compares each one
// with the sample predicted on acceptance of its item.
// ----------------------------------------------------------------------------
module testbench;

    import rdl_pkg::*;

    localparam int DEPTH       = 4096;
    localparam int SAMPLE_BITS = 24;
    localparam int HALF_PERIOD = 10;
    localparam int RANDOM_ITEMS = 1550;
    localparam int TAIL_CYCLES  = 40;       // comfortably over the ramp latency
    localparam int HOLD_CYCLES  = 300;      // long receiver hold-off
    localparam longint WATCHDOG_NS = 64'd10_000_000;

    // Unmapped register index: writes to it must leave every setting alone
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd7;

    typedef enum logic [1:0] {STEP_ITEM, STEP_REG_WRITE, STEP_DRAIN} step_kind_e;

    typedef struct {
        step_kind_e               kind;
        logic [SAMPLE_BITS-1:0]   sample;
        logic [POS_W-1:0]         pos;
        logic                     commit;
        logic [CFG_IDX_W-1:0]     idx;
        logic [CFG_DATA_W-1:0]    data;
    } step_t;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT ports. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [CFG_IDX_W-1:0]           cfg_index = '0;
    logic [CFG_DATA_W-1:0]          cfg_data = '0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic signed [SAMPLE_BITS-1:0]  sample_in = '0;
    logic [POS_W-1:0]               position_in_block = '0;
    logic                           commit_delay = 1'b0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic signed [SAMPLE_BITS-1:0]  sample_out;

    always #(HALF_PERIOD) clk = ~clk;

    ramped_delay_line #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .sample_in         (sample_in),
        .position_in_block (position_in_block),
        .commit_delay      (commit_delay),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .sample_out        (sample_out)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    step_t                  pending_steps[$];
    logic [SAMPLE_BITS-1:0] expected_samples[$];
    int                     mismatches = 0;
    int                     items_taken = 0;    // bumped by NBA, read by both sides
    int                     results_seen = 0;
    int                     hold_left = 0;

    // Both sides stop idling for a stretch in the middle of the run
    wire steady_run = (items_taken >= 700) && (items_taken < 1000);

    // ------------------------------------------------------------------------
    // Predictor: private copy of the sample memory, write pointer, committed
    // ramp origin and the four registers, all at their reset values.
    // ------------------------------------------------------------------------
    logic [SAMPLE_BITS-1:0] delay_store[0:DEPTH-1];
    int unsigned            wr_ptr = 0;
    int unsigned            ramp_origin = 0;
    int unsigned            reg_buf_len = 4096;
    int unsigned            reg_target = 0;
    logic                   reg_ramp_on = 1'b0;
    int unsigned            reg_block_len = 256;

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_BUFFER_LENGTH: reg_buf_len   = data;
            REG_TARGET_DELAY:  reg_target    = data;
            REG_RAMP_ENABLE:   reg_ramp_on   = data[0];
            REG_BLOCK_LENGTH:  reg_block_len = data;
            default: ;
        endcase
    endfunction

    // Works out the sample that leaves for one item and moves the state on.
    function automatic logic [SAMPLE_BITS-1:0] predict_delayed_sample(
        input logic [SAMPLE_BITS-1:0] smp,
        input logic [POS_W-1:0]       pos,
        input logic                   commit);
        int unsigned            len, tgt, org, wp, p, blen, dly, rd;
        logic [SAMPLE_BITS-1:0] res;
        len = reg_buf_len;
        if (len < 1)
            len = 1;
        if (len > DEPTH)
            len = DEPTH;
        tgt = (reg_target > len) ? len : reg_target;
        org = (ramp_origin > len) ? len : ramp_origin;
        wp  = (wr_ptr >= len) ? 0 : wr_ptr;     // length shrank under the pointer
        if (reg_ramp_on)
        begin
            blen = (reg_block_len == 0) ? 1 : reg_block_len;
            p    = pos;
            if (p > blen)
                p = blen;                       // ramp holds at target
            // quotient truncated towards zero either way round
            if (tgt >= org)
                dly = org + ((tgt - org) * p) / blen;
            else
                dly = org - ((org - tgt) * p) / blen;
        end
        else
            dly = tgt;
        if (dly == 0)
            res = smp;
        else
        begin
            rd = (wp >= dly) ? (wp - dly) : (wp + len - dly);
            if (rd >= len)
                rd = 0;
            res = delay_store[rd];
        end
        delay_store[wp] = smp;
        wp = wp + 1;
        if (wp >= len)
            wp = 0;
        wr_ptr = wp;
        if (commit)
            ramp_origin = tgt;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Queue helpers
    // ------------------------------------------------------------------------
    function automatic void queue_item(input logic [SAMPLE_BITS-1:0] smp,
                                       input int unsigned pos, input bit commit);
        step_t s;
        s.kind   = STEP_ITEM;
        s.sample = smp;
        s.pos    = pos[POS_W-1:0];
        s.commit = commit;
        s.idx    = '0;
        s.data   = '0;
        pending_steps.push_back(s);
    endfunction

    function automatic void queue_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input int unsigned data);
        step_t s;
        s.kind   = STEP_REG_WRITE;
        s.sample = '0;
        s.pos    = '0;
        s.commit = 1'b0;
        s.idx    = idx;
        s.data   = data[CFG_DATA_W-1:0];
        pending_steps.push_back(s);
    endfunction

    // Sender stops here until every outstanding sample has come back
    function automatic void queue_drain();
        step_t s;
        s.kind   = STEP_DRAIN;
        s.sample = '0;
        s.pos    = '0;
        s.commit = 1'b0;
        s.idx    = '0;
        s.data   = '0;
        pending_steps.push_back(s);
    endfunction

    // ------------------------------------------------------------------------
    // Driver: retires accepted items and writes, predicts on acceptance, then
    // offers the next step. Each valid gets a single NBA per edge.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : driver
        logic  hold_in, hold_cfg, next_in, next_cfg;
        step_t step;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            cfg_valid <= 1'b0;
        end
        else
        begin
            hold_in  = in_valid && !in_ready;
            hold_cfg = cfg_valid && !cfg_ready;
            next_in  = hold_in;
            next_cfg = hold_cfg;
            if (in_valid && in_ready)
            begin
                expected_samples.push_back(
                    predict_delayed_sample(sample_in, position_in_block, commit_delay));
                items_taken <= items_taken + 1;
            end
            if (cfg_valid && cfg_ready)
                apply_register(cfg_index, cfg_data);
            if (!hold_in && !hold_cfg && pending_steps.size() != 0)
            begin
                case (pending_steps[0].kind)
                    STEP_ITEM:
                    begin
                        // random gap before offering the next item
                        if (steady_run || $urandom_range(99) >= 29)
                        begin
                            step = pending_steps.pop_front();
                            next_in           = 1'b1;
                            sample_in         <= step.sample;
                            position_in_block <= step.pos;
                            commit_delay      <= step.commit;
                        end
                    end
                    STEP_REG_WRITE:
                    begin
                        step = pending_steps.pop_front();
                        next_cfg  = 1'b1;
                        cfg_index <= step.idx;
                        cfg_data  <= step.data;
                    end
                    default:
                    begin
                        if (expected_samples.size() == 0)
                            void'(pending_steps.pop_front());
                    end
                endcase
            end
            in_valid  <= next_in;
            cfg_valid <= next_cfg;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each taken sample against the oldest prediction and
    // drives out_ready, including two long hold-offs that back the block up.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : monitor
        logic [SAMPLE_BITS-1:0] want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen = results_seen + 1;
                if (expected_samples.size() == 0)
                begin
                    $display("%0t: sample with none pending: expected none, actual %h",
                             $time, sample_out);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (sample_out !== want)
                    begin
                        $display("%0t: sample_out mismatch: expected %h, actual %h",
                                 $time, want, sample_out);
                        mismatches = mismatches + 1;
                    end
                end
                if (results_seen == 400 || results_seen == 1100)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left = hold_left - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= steady_run || ($urandom_range(99) >= 29);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus: directed corner cases, then random phases. Every phase starts
    // with a drain so registers only change while the block is idle.
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int          k, n, r, span, pos, random_items;
        int unsigned plan_len, eff_len, plan_blk, val;
        bit          tidy, commit;
        logic [31:0] rnd;

        foreach (delay_store[i])
            delay_store[i] = '0;

        // Reset settings: zero delay, so both extremes bypass straight through
        queue_item(24'h7FFFFF, 0, 1'b0);
        queue_item(24'h800000, 4095, 1'b1);
        queue_drain();

        // Four entries with a delay equal to the length: each read returns the
        // entry about to be overwritten
        queue_reg(REG_BUFFER_LENGTH, 4);
        queue_reg(REG_TARGET_DELAY, 4);
        for (k = 0; k < 5; k++)
            queue_item(SAMPLE_BITS'(24'h100000 + k), k, k == 4);
        queue_drain();

        // Oversized length and target, zero block length, ramp on; the last
        // position lies past the block so the delay sits at the target
        queue_reg(REG_BUFFER_LENGTH, 8191);
        queue_reg(REG_TARGET_DELAY, 8191);
        queue_reg(REG_RAMP_ENABLE, 1);
        queue_reg(REG_BLOCK_LENGTH, 0);
        queue_item(24'h555555, 0, 1'b0);
        queue_item(24'hAAAAAA, 4095, 1'b1);
        queue_drain();

        // Zero length: start and target clamp to one, pointer restarts
        queue_reg(REG_BUFFER_LENGTH, 0);
        queue_reg(REG_TARGET_DELAY, 3);
        queue_reg(REG_BLOCK_LENGTH, 8191);
        queue_item(24'h123456, 0, 1'b0);
        queue_item(24'hFEDCBA, 100, 1'b0);
        queue_drain();

        // Falling ramp from a clamped start down to 3 over a block of 5
        queue_reg(REG_BUFFER_LENGTH, 16);
        queue_reg(REG_TARGET_DELAY, 3);
        queue_reg(REG_BLOCK_LENGTH, 5);
        for (k = 0; k < 6; k++)
            queue_item(SAMPLE_BITS'(24'h200000 + k), k, k == 5);
        queue_drain();

        // Full length and block, rising ramp nearly to the top
        queue_reg(REG_BUFFER_LENGTH, 4096);
        queue_reg(REG_TARGET_DELAY, 4096);
        queue_reg(REG_BLOCK_LENGTH, 4096);
        queue_reg(REG_SPARE, 8191);
        queue_item(24'h0F0F0F, 1, 1'b0);
        queue_item(24'hF0F0F0, 4095, 1'b0);
        queue_drain();

        // Only bit 0 of the ramp register counts: this selects direct mode
        queue_reg(REG_RAMP_ENABLE, 2);
        queue_reg(REG_TARGET_DELAY, 1);
        queue_reg(REG_BUFFER_LENGTH, 2);
        queue_reg(REG_BLOCK_LENGTH, 1);
        queue_item(24'h000001, 0, 1'b1);
        queue_item(24'hFFFFFE, 1, 1'b0);

        plan_blk     = 1;
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            queue_drain();

            r = $urandom_range(99);
            if (r < 70)
                plan_len = $urandom_range(64, 1);
            else if (r < 85)
                plan_len = $urandom_range(4096, 65);
            else if (r < 90)
                plan_len = 4096;
            else if (r < 95)
                plan_len = 0;
            else
                plan_len = $urandom_range(8191, 4097);
            queue_reg(REG_BUFFER_LENGTH, plan_len);
            eff_len = (plan_len == 0) ? 1 : ((plan_len > DEPTH) ? DEPTH : plan_len);

            r = $urandom_range(99);
            if (r < 70)
                val = $urandom_range(eff_len, 0);
            else if (r < 80)
                val = eff_len;
            else if (r < 90)
                val = 0;
            else
                val = $urandom_range(8191, 0);
            queue_reg(REG_TARGET_DELAY, val);

            if ($urandom_range(1) == 1)
            begin
                val = ($urandom_range(9) == 0) ? $urandom_range(8191, 0) : $urandom_range(1);
                queue_reg(REG_RAMP_ENABLE, val);
            end

            if ($urandom_range(1) == 1)
            begin
                r = $urandom_range(99);
                if (r < 75)
                    plan_blk = $urandom_range(32, 1);
                else if (r < 85)
                    plan_blk = $urandom_range(4096, 33);
                else if (r < 90)
                    plan_blk = 0;
                else if (r < 95)
                    plan_blk = 4096;
                else
                    plan_blk = 8191;
                queue_reg(REG_BLOCK_LENGTH, plan_blk);
            end

            // Mostly whole blocks with a commit on the last sample; the rest
            // is noise with random positions and commits
            span = (plan_blk == 0) ? 1 : ((plan_blk > 4096) ? 4096 : plan_blk);
            tidy = ($urandom_range(99) < 80);
            n    = $urandom_range(90, 20);
            pos  = 0;
            for (k = 0; k < n; k++)
            begin
                rnd = $urandom();
                if (tidy && $urandom_range(9) != 0)
                    queue_item(rnd[SAMPLE_BITS-1:0], pos, pos == span - 1);
                else
                begin
                    commit = 1'($urandom_range(1));
                    queue_item(rnd[SAMPLE_BITS-1:0], $urandom_range(4095), commit);
                end
                pos = (pos + 1) % span;
            end
            random_items = random_items + n;
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_steps.size() == 0 && !in_valid && !cfg_valid);
        wait (expected_samples.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_samples.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog: covers the clearing sweep after reset and many times the
    // slowest expected run
    initial
    begin : watchdog
        #(WATCHDOG_NS);
        $display("%0t: timeout with %0d samples outstanding", $time, expected_samples.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
